>>> hw/rtl/serial_frame_deframer_top_assert.svh
// Assertion macros shared by the deframer modules.
// Each expects clk and arst_n in scope.
`ifndef SERIAL_FRAME_DEFRAMER_TOP_ASSERT_SVH
`define SERIAL_FRAME_DEFRAMER_TOP_ASSERT_SVH

// Same-cycle implication.
`define SFD_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define SFD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hw/rtl/sfd_pkg.sv
package sfd_pkg;

	typedef enum logic [1:0] {
		PH_HUNT,
		PH_HDR,
		PH_FRAME
	} phase_t;

	typedef enum logic [1:0] {
		CHK_NONE,
		CHK_XOR,
		CHK_SUM,
		CHK_CRC
	} chk_mode_t;

	typedef enum logic [1:0] {
		REG_HEADER,
		REG_MIN_LEN,
		REG_CHECK_MODE
	} reg_idx_t;

	localparam logic [2:0] PART_HEADER  = 3'd0;
	localparam logic [2:0] PART_LENGTH  = 3'd1;
	localparam logic [2:0] PART_COMMAND = 3'd2;
	localparam logic [2:0] PART_STATUS  = 3'd3;
	localparam logic [2:0] PART_PAYLOAD = 3'd4;
	localparam logic [2:0] PART_CHECK   = 3'd5;

	localparam logic [7:0] HEADER_RESET   = 8'hAA;
	localparam logic [7:0] MIN_LEN_RESET  = 8'd5;
	localparam logic [7:0] MIN_LEN_FLOOR  = 8'd5;
	localparam logic [7:0] CRC_POLY       = 8'h07;

	localparam int RESULT_DEPTH = 8;

	typedef struct packed {
		logic [7:0] header_value;
		logic [7:0] min_frame_length;
		chk_mode_t  check_mode;
	} cfg_t;

	typedef struct packed {
		logic [2:0] part;
		logic [7:0] data_byte;
		logic [7:0] byte_offset;
		logic       frame_end;
		logic       frame_good;
	} result_t;

	typedef struct packed {
		logic [1:0] n;
		result_t    r0;
		result_t    r1;
	} push_t;

	function automatic logic [7:0] sfd_check_update(chk_mode_t mode, logic [7:0] acc,
		logic [7:0] b);
		logic [7:0] v;
		v = acc ^ b;
		unique case (mode)
			CHK_XOR: return acc ^ b;
			CHK_SUM: return acc + b;
			CHK_CRC: begin
				for (int i = 0; i < 8; i++) begin
					v = v[7] ? ((v << 1) ^ CRC_POLY) : (v << 1);
				end
				return v;
			end
			default: return 8'h00;
		endcase
	endfunction

endpackage

>>> hw/rtl/serial_frame_deframer_top.sv
// A byte accepted at the input is registered in the parser, parsed there and written into the result
// queue, and its first result is then offered on out_valid from the head of that queue.
// Throughput: one byte per cycle; a length byte yields two results, absorbed by the
// RESULT_DEPTH-entry queue, so in_ready drops only while the consumer stalls.
// Reset (arst_n low, asynchronous): hunting for a header, queue empty, registers at header
// 0xAA, minimum length 5, check none.
module serial_frame_deframer_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [2:0] part,
	output logic [7:0] data_byte,
	output logic [7:0] byte_offset,
	output logic       frame_end,
	output logic       frame_good,
	input  logic       cfg_write_en,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_data
);
	import sfd_pkg::*;

	cfg_t    cfg_q;
	push_t   push;
	result_t head;
	logic    accept;

	assign accept = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.header_value     <= HEADER_RESET;
			cfg_q.min_frame_length <= MIN_LEN_RESET;
			cfg_q.check_mode       <= CHK_NONE;
		end else if (cfg_write_en) begin
			unique case (cfg_index)
				REG_HEADER:     cfg_q.header_value     <= cfg_data;
				REG_MIN_LEN:    cfg_q.min_frame_length <= cfg_data;
				REG_CHECK_MODE: cfg_q.check_mode       <= chk_mode_t'(cfg_data[1:0]);
				default: ;
			endcase
		end
	end

	sfd_parse u_parse (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.rx_byte (rx_byte),
		.cfg     (cfg_q),
		.push    (push)
	);

	sfd_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.pop       (out_ready),
		.not_empty (out_valid),
		.has_room  (in_ready),
		.head      (head)
	);

	assign part        = head.part;
	assign data_byte   = head.data_byte;
	assign byte_offset = head.byte_offset;
	assign frame_end   = head.frame_end;
	assign frame_good  = head.frame_good;

endmodule

>>> hw/rtl/sfd_parse.sv
module sfd_parse (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          accept,
	input  logic [7:0]    rx_byte,
	input  sfd_pkg::cfg_t cfg,
	output sfd_pkg::push_t push
);
	import sfd_pkg::*;

	logic       valid_s1;
	logic [7:0] byte_s1;

	phase_t     phase_q, phase_d;
	logic [7:0] len_q, len_d;
	logic [7:0] seen_q, seen_d;
	logic [7:0] chk_q, chk_d;
	logic [7:0] held_q, held_d;

	logic [7:0] minlen;
	logic [7:0] upd_chk;
	logic [7:0] start_chk;
	logic [8:0] next_off;
	logic [2:0] mid_part;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1 <= rx_byte;
		end
		held_q <= held_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			len_q   <= '0;
			seen_q  <= '0;
			chk_q   <= '0;
		end else begin
			phase_q <= phase_d;
			len_q   <= len_d;
			seen_q  <= seen_d;
			chk_q   <= chk_d;
		end
	end

	always_comb begin
		phase_d   = phase_q;
		len_d     = len_q;
		seen_d    = seen_q;
		chk_d     = chk_q;
		held_d    = held_q;
		push      = '0;
		minlen    = (cfg.min_frame_length < MIN_LEN_FLOOR) ? MIN_LEN_FLOOR
			: cfg.min_frame_length;
		upd_chk   = sfd_check_update(cfg.check_mode, chk_q, byte_s1);
		start_chk = sfd_check_update(cfg.check_mode, 8'h00, byte_s1);
		next_off  = {1'b0, seen_q} + 9'd1;
		if (seen_q == 8'd2) begin
			mid_part = PART_COMMAND;
		end else if (seen_q == 8'd3) begin
			mid_part = PART_STATUS;
		end else begin
			mid_part = PART_PAYLOAD;
		end

		if (valid_s1) begin
			unique case (phase_q)
				PH_HDR: begin
					if (byte_s1 < minlen) begin
						if (byte_s1 == cfg.header_value) begin
							phase_d = PH_HDR;
							held_d  = byte_s1;
							chk_d   = start_chk;
							seen_d  = 8'd1;
						end else begin
							phase_d = PH_HUNT;
							len_d   = '0;
							seen_d  = '0;
							chk_d   = '0;
						end
					end else begin
						phase_d = PH_FRAME;
						len_d   = byte_s1;
						chk_d   = upd_chk;
						seen_d  = 8'd2;
						push.n  = 2'd2;
						push.r0 = '{part: PART_HEADER, data_byte: held_q,
							byte_offset: 8'd0, frame_end: 1'b0, frame_good: 1'b0};
						push.r1 = '{part: PART_LENGTH, data_byte: byte_s1,
							byte_offset: 8'd1, frame_end: 1'b0, frame_good: 1'b0};
					end
				end
				PH_FRAME: begin
					push.n = 2'd1;
					if (next_off >= {1'b0, len_q}) begin
						push.r0 = '{part: PART_CHECK, data_byte: byte_s1,
							byte_offset: seen_q, frame_end: 1'b1,
							frame_good: (cfg.check_mode == CHK_NONE) || (chk_q == byte_s1)};
						phase_d = PH_HUNT;
						len_d   = '0;
						seen_d  = '0;
						chk_d   = '0;
					end else begin
						push.r0 = '{part: mid_part, data_byte: byte_s1,
							byte_offset: seen_q, frame_end: 1'b0, frame_good: 1'b0};
						chk_d   = upd_chk;
						seen_d  = next_off[7:0];
					end
				end
				default: begin
					if (byte_s1 == cfg.header_value) begin
						phase_d = PH_HDR;
						held_d  = byte_s1;
						chk_d   = start_chk;
						seen_d  = 8'd1;
					end else begin
						phase_d = PH_HUNT;
						len_d   = '0;
						seen_d  = '0;
						chk_d   = '0;
					end
				end
			endcase
		end
	end

`include "serial_frame_deframer_top_assert.svh"

	`SFD_ASSERT_NOW(a_end_is_check, push.n != 2'd0 && push.r0.frame_end,
		push.r0.part == PART_CHECK, "frame end on a byte that is not the check byte")
	`SFD_ASSERT_NOW(a_pair_is_head, push.n == 2'd2,
		push.r0.part == PART_HEADER && push.r1.byte_offset == 8'd1,
		"double beat not header and length")
	`SFD_ASSERT_NOW(a_frame_len, phase_q == PH_FRAME,
		len_q >= MIN_LEN_FLOOR && seen_q >= 8'd2 && seen_q < len_q,
		"frame state out of range")

endmodule

>>> hw/rtl/sfd_fifo.sv
module sfd_fifo (
	input  logic             clk,
	input  logic             arst_n,
	input  sfd_pkg::push_t   push,
	input  logic             pop,
	output logic             not_empty,
	output logic             has_room,
	output sfd_pkg::result_t head
);
	import sfd_pkg::*;

	localparam int DEPTH = RESULT_DEPTH;
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	result_t            mem [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic [PTR_W-1:0]   wr_ptr_p1;
	logic               do_pop;

	assign wr_ptr_p1 = wr_ptr_q + PTR_W'(1);
	assign not_empty = (count_q != '0);
	assign do_pop    = pop && not_empty;
	assign has_room  = (count_q <= CNT_W'(DEPTH - 4));
	assign head      = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push.n != 2'd0) begin
			mem[wr_ptr_q] <= push.r0;
		end
		if (push.n == 2'd2) begin
			mem[wr_ptr_p1] <= push.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PTR_W'(push.n);
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			count_q <= count_q + CNT_W'(push.n) - CNT_W'(do_pop);
		end
	end

`include "serial_frame_deframer_top_assert.svh"

	`SFD_ASSERT_NOW(a_no_overflow, 1'b1,
		({1'b0, count_q} + (CNT_W + 1)'(push.n)) <= (CNT_W + 1)'(DEPTH),
		"result queue overflow")
	`SFD_ASSERT_NOW(a_ptr_count, 1'b1,
		PTR_W'(wr_ptr_q - rd_ptr_q) == PTR_W'(count_q), "queue pointers disagree with count")
	`SFD_ASSERT_NEXT(a_count_step, 1'b1,
		count_q == $past(count_q) + CNT_W'($past(push.n)) - CNT_W'($past(do_pop)),
		"queue count step wrong")

endmodule

>>> tb/sv/testbench.sv
module testbench;
	import sfd_pkg::*;

	class frame_scoreboard;
		logic [7:0] hdr;
		logic [7:0] min_len;
		chk_mode_t  mode;
		phase_t     ph;
		logic [7:0] flen;
		logic [7:0] seen;
		logic [7:0] acc;
		logic [7:0] held;
		result_t    expected_beats[$];
		int         errors;

		function new();
			hdr = HEADER_RESET;
			min_len = MIN_LEN_RESET;
			mode = CHK_NONE;
			held = 8'h00;
			errors = 0;
			hunt();
		endfunction

		function void hunt();
			ph = PH_HUNT;
			flen = 8'h00;
			seen = 8'h00;
			acc = 8'h00;
		endfunction

		function void open_header(logic [7:0] b);
			ph = PH_HDR;
			held = b;
			acc = fold(mode, 8'h00, b);
			seen = 8'd1;
		endfunction

		function logic [7:0] fold(chk_mode_t m, logic [7:0] a, logic [7:0] b);
			logic [7:0] r;
			r = a ^ b;
			case (m)
				CHK_XOR: return r;
				CHK_SUM: return a + b;
				CHK_CRC: begin
					repeat (8) r = {r[6:0], 1'b0} ^ (r[7] ? CRC_POLY : 8'h00);
					return r;
				end
				default: return 8'h00;
			endcase
		endfunction

		function logic [7:0] min_limit();
			return (min_len < MIN_LEN_FLOOR) ? MIN_LEN_FLOOR : min_len;
		endfunction

		function void set_reg(reg_idx_t idx, logic [7:0] v);
			case (idx)
				REG_HEADER: hdr = v;
				REG_MIN_LEN: min_len = v;
				REG_CHECK_MODE: mode = chk_mode_t'(v[1:0]);
				default: ;
			endcase
		endfunction

		function void push(logic [2:0] p, logic [7:0] d, logic [7:0] off, logic e, logic g);
			result_t r;
			r.part = p;
			r.data_byte = d;
			r.byte_offset = off;
			r.frame_end = e;
			r.frame_good = g;
			expected_beats.push_back(r);
		endfunction

		function int pending();
			return expected_beats.size();
		endfunction

		function int note_byte(logic [7:0] b);
			logic [2:0] p;
			case (ph)
				PH_HDR: begin
					if (b < min_limit()) begin
						if (b == hdr)
							open_header(b);
						else
							hunt();
						return 0;
					end
					flen = b;
					acc = fold(mode, acc, b);
					seen = 8'd2;
					ph = PH_FRAME;
					push(PART_HEADER, held, 8'd0, 1'b0, 1'b0);
					push(PART_LENGTH, b, 8'd1, 1'b0, 1'b0);
					return 2;
				end
				PH_FRAME: begin
					if (int'(seen) + 1 >= int'(flen)) begin
						push(PART_CHECK, b, seen, 1'b1, (mode == CHK_NONE) || (acc == b));
						hunt();
						return 1;
					end
					p = (seen == 8'd2) ? PART_COMMAND : (seen == 8'd3) ? PART_STATUS : PART_PAYLOAD;
					push(p, b, seen, 1'b0, 1'b0);
					acc = fold(mode, acc, b);
					seen = seen + 8'd1;
					return 1;
				end
				default: begin
					if (b == hdr)
						open_header(b);
					else
						hunt();
					return 0;
				end
			endcase
		endfunction

		function void check_beat(result_t got);
			result_t e;
			if (expected_beats.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected beat: part %0d data %02h offset %0d end %b good %b",
						got.part, got.data_byte, got.byte_offset, got.frame_end, got.frame_good);
				return;
			end
			e = expected_beats.pop_front();
			if (got.part !== e.part || got.data_byte !== e.data_byte ||
				got.byte_offset !== e.byte_offset || got.frame_end !== e.frame_end ||
				got.frame_good !== e.frame_good) begin
				errors++;
				if (errors <= 10) begin
					$display("beat mismatch: expected part %0d data %02h offset %0d end %b good %b",
						e.part, e.data_byte, e.byte_offset, e.frame_end, e.frame_good);
					$display("  got part %0d data %02h offset %0d end %b good %b",
						got.part, got.data_byte, got.byte_offset, got.frame_end, got.frame_good);
				end
			end
		endfunction
	endclass

	localparam int QUIET_LIMIT = 2000;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	logic [7:0] rx_byte;
	logic       out_valid;
	logic       out_ready;
	logic [2:0] part;
	logic [7:0] data_byte;
	logic [7:0] byte_offset;
	logic       frame_end;
	logic       frame_good;
	logic       cfg_write_en;
	logic [1:0] cfg_index;
	logic [7:0] cfg_data;

	frame_scoreboard sb = new();
	bit idle_on = 1'b1;
	int live_bytes = 0;

	serial_frame_deframer_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.rx_byte(rx_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.part(part),
		.data_byte(data_byte),
		.byte_offset(byte_offset),
		.frame_end(frame_end),
		.frame_good(frame_good),
		.cfg_write_en(cfg_write_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	task automatic send_byte(input logic [7:0] b);
		@(negedge clk);
		if (idle_on && $urandom_range(0, 5) == 0) begin
			in_valid = 1'b0;
			repeat ($urandom_range(1, 15)) @(negedge clk);
		end
		in_valid = 1'b1;
		rx_byte = b;
		do @(posedge clk); while (!in_ready);
		if (sb.note_byte(b) > 0)
			live_bytes++;
	endtask

	task automatic settle();
		@(negedge clk);
		in_valid = 1'b0;
		while (sb.pending() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic program_regs(input logic [7:0] h, input logic [7:0] m, input chk_mode_t cm);
		settle();
		cfg_write_en = 1'b1;
		cfg_index = REG_HEADER;
		cfg_data = h;
		sb.set_reg(REG_HEADER, h);
		@(negedge clk);
		cfg_index = REG_MIN_LEN;
		cfg_data = m;
		sb.set_reg(REG_MIN_LEN, m);
		@(negedge clk);
		cfg_index = REG_CHECK_MODE;
		cfg_data = {6'd0, cm};
		sb.set_reg(REG_CHECK_MODE, {6'd0, cm});
		@(negedge clk);
		cfg_write_en = 1'b0;
	endtask

	// stop early to leave the frame open across a register change
	task automatic run_body(input bit good, input bit open);
		bit last;
		while (sb.ph == PH_FRAME && !(open && sb.seen >= 8'd4)) begin
			last = int'(sb.seen) + 1 >= int'(sb.flen);
			send_byte((last && good) ? sb.acc : 8'($urandom_range(0, 255)));
		end
	endtask

	task automatic send_frame(input int extra, input bit good, input bit open);
		int len;
		len = int'(sb.min_limit()) + extra;
		if (len > 255)
			len = 255;
		send_byte(sb.hdr);
		send_byte(8'(len));
		run_body(good, open);
	endtask

	task automatic run_phase(input logic [7:0] h, input logic [7:0] m, input chk_mode_t cm,
		input int target, input bit open_end);
		int start;
		int unsigned pick;
		logic [7:0] lim;
		program_regs(h, m, cm);
		run_body(1'b1, 1'b0);
		start = live_bytes;
		while (live_bytes - start < target) begin
			pick = $urandom_range(0, 9);
			lim = sb.min_limit();
			if (pick < 7) begin
				send_frame($urandom_range(0, 12), $urandom_range(0, 4) != 0, 1'b0);
			end else if (pick < 9) begin
				send_byte(sb.hdr);
				send_byte((sb.hdr < lim && pick == 8) ? sb.hdr :
					8'($urandom_range(0, int'(lim) - 1)));
			end else begin
				repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)));
			end
		end
		if (open_end)
			send_frame($urandom_range(0, 12), 1'b1, 1'b1);
	endtask

	initial begin
		int stall;
		stall = 0;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall > 0) begin
				out_ready = 1'b0;
				stall--;
			end else begin
				out_ready = 1'b1;
				if (idle_on && $urandom_range(0, 6) == 0)
					stall = $urandom_range(1, 15);
			end
		end
	end

	always @(posedge clk) begin
		result_t got;
		if (arst_n && out_valid && out_ready) begin
			got.part = part;
			got.data_byte = data_byte;
			got.byte_offset = byte_offset;
			got.frame_end = frame_end;
			got.frame_good = frame_good;
			sb.check_beat(got);
		end
	end

	initial begin
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("serial_frame_deframer_top test failed");
		$finish;
	end

	initial begin
		logic [7:0] opening [] = '{8'h11, HEADER_RESET, 8'h03,
			HEADER_RESET, 8'h05, 8'h00, 8'hFF, 8'h7E,
			HEADER_RESET, 8'h06, 8'h10, 8'h20, 8'h30, 8'h40};
		logic [7:0] relock [] = '{8'h03, 8'h03, 8'h04, 8'h03, 8'h05, 8'h11, 8'h22};
		arst_n = 1'b0;
		in_valid = 1'b0;
		rx_byte = 8'h00;
		cfg_write_en = 1'b0;
		cfg_index = REG_HEADER;
		cfg_data = 8'h00;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (opening[i])
			send_byte(opening[i]);
		program_regs(8'h03, 8'h00, CHK_XOR);
		foreach (relock[i])
			send_byte(relock[i]);
		send_byte(sb.acc);

		run_phase(8'h55, 8'd5, CHK_XOR, 20, 1'b1);
		run_phase(8'h00, 8'd0, CHK_SUM, 20, 1'b1);
		run_phase(8'hFF, 8'd9, CHK_CRC, 20, 1'b0);
		run_phase(8'h3C, 8'd255, CHK_CRC, 200, 1'b0);
		run_phase(8'($urandom_range(0, 255)), 8'($urandom_range(5, 12)),
			chk_mode_t'($urandom_range(0, 3)), 20, 1'b1);
		run_phase(8'h02, 8'd3, CHK_NONE, 15, 1'b0);
		idle_on = 1'b0;
		run_phase(HEADER_RESET, 8'd6, CHK_CRC, 15, 1'b0);

		settle();
		repeat (10) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("serial_frame_deframer_top test passed");
		else
			$display("serial_frame_deframer_top test failed");
		$finish;
	end
endmodule

>>> sim.f
+incdir+hw/rtl
hw/rtl/sfd_pkg.sv
hw/rtl/sfd_parse.sv
hw/rtl/sfd_fifo.sv
hw/rtl/serial_frame_deframer_top.sv
tb/sv/testbench.sv
